// ===== hdl/calculator_key_line_editor_unit_macros.svh =====
// Assertion macros for the line editor RTL.
`ifndef CALCULATOR_KEY_LINE_EDITOR_UNIT_MACROS_SVH
`define CALCULATOR_KEY_LINE_EDITOR_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CKLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on the edge that follows a reset cycle.
`define CKLE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> prop) \
        else $error(msg);

`endif

// ===== hdl/ckle_pkg.sv =====
// Package with types, codes and the key token table of the line editor.
package ckle_pkg;

    localparam int CURSOR_W = 6;
    localparam int KEY_W    = 8;
    localparam int CHAR_W   = 8;
    localparam int TOK_MAX  = 6;
    localparam int TLEN_W   = 3;
    localparam int OLEN_W   = 6;

    typedef enum logic [1:0] {
        K_INSERT    = 2'd0,
        K_BACKSPACE = 2'd1,
        K_CLEAR     = 2'd2,
        K_READ      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_UNKNOWN    = 2'd1,
        ST_NO_ROOM    = 2'd2,
        ST_BAD_CURSOR = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_EXEC  = 3'd1,
        S_SHIFT = 3'd2,
        S_TOKEN = 3'd3,
        S_READ  = 3'd4,
        S_DONE  = 3'd5
    } t_state;

    typedef struct packed {
        logic [TLEN_W-1:0]                len;
        logic [TOK_MAX-1:0][CHAR_W-1:0]   chars;
    } t_token;

    typedef struct packed {
        t_status             status;
        logic [TLEN_W-1:0]   tlen;
        logic [OLEN_W-1:0]   new_len;
        logic [CHAR_W-1:0]   rch;
    } t_result;

    function automatic t_token mk_tok(input logic [TLEN_W-1:0] n,
                                      input logic [CHAR_W-1:0] c0,
                                      input logic [CHAR_W-1:0] c1,
                                      input logic [CHAR_W-1:0] c2,
                                      input logic [CHAR_W-1:0] c3,
                                      input logic [CHAR_W-1:0] c4,
                                      input logic [CHAR_W-1:0] c5);
        t_token t;
        t.len      = n;
        t.chars[0] = c0;
        t.chars[1] = c1;
        t.chars[2] = c2;
        t.chars[3] = c3;
        t.chars[4] = c4;
        t.chars[5] = c5;
        return t;
    endfunction

    function automatic t_token key_token(input logic [KEY_W-1:0] code);
        t_token t;
        t = mk_tok(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        if (code >= 8'h2A && code <= 8'h39) begin
            t = mk_tok(3'd1, code, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        end else begin
            unique case (code)
                8'h83: t = mk_tok(3'd1, "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'h06: t = mk_tok(3'd1, "(", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'h07: t = mk_tok(3'd1, ")", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'h8B: t = mk_tok(3'd1, "i", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'h8E: t = mk_tok(3'd1, "!", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'hB1: t = mk_tok(3'd1, "x", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'hB2: t = mk_tok(3'd1, "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'hB3: t = mk_tok(3'd1, "z", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'h0D: t = mk_tok(3'd1, "^", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                8'd18: t = mk_tok(3'd4, "s", "i", "n", "(", 8'h00, 8'h00);
                8'd19: t = mk_tok(3'd4, "c", "o", "s", "(", 8'h00, 8'h00);
                8'd20: t = mk_tok(3'd4, "t", "a", "n", "(", 8'h00, 8'h00);
                8'd12: t = mk_tok(3'd2, "^", "2", 8'h00, 8'h00, 8'h00, 8'h00);
                8'd15: t = mk_tok(3'd3, "e", "^", "(", 8'h00, 8'h00, 8'h00);
                8'h8F: t = mk_tok(3'd3, "l", "n", "(", 8'h00, 8'h00, 8'h00);
                8'd23: t = mk_tok(3'd3, "A", "n", "s", 8'h00, 8'h00, 8'h00);
                8'd11: t = mk_tok(3'd4, "a", "b", "s", "(", 8'h00, 8'h00);
                8'd16: t = mk_tok(3'd4, "1", "0", "^", "(", 8'h00, 8'h00);
                8'h90: t = mk_tok(3'd4, "l", "o", "g", "(", 8'h00, 8'h00);
                8'h92: t = mk_tok(3'd5, "a", "s", "i", "n", "(", 8'h00);
                8'h93: t = mk_tok(3'd5, "a", "c", "o", "s", "(", 8'h00);
                8'h94: t = mk_tok(3'd5, "a", "t", "a", "n", "(", 8'h00);
                8'h8C: t = mk_tok(3'd6, "^", "(", "1", "/", "2", ")");
                8'h8D: t = mk_tok(3'd4, "^", "(", "1", "/", 8'h00, 8'h00);
                8'd14: t = mk_tok(3'd5, "^", "(", "-", "1", ")", 8'h00);
                8'd120: t = mk_tok(3'd5, "s", "i", "n", "h", "(", 8'h00);
                8'd121: t = mk_tok(3'd5, "c", "o", "s", "h", "(", 8'h00);
                8'd122: t = mk_tok(3'd5, "t", "a", "n", "h", "(", 8'h00);
                default: t = mk_tok(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            endcase
        end
        return t;
    endfunction

endpackage

// ===== hdl/calculator_key_line_editor_unit.sv =====
// Top level of the calculator key line editor with its output register.
//
// Input stream (s_axis): one beat is one item. tuser carries the kind
// (insert key token, backspace, clear line, read character); tdata carries
// the keypad code and the cursor. Output stream (m_axis): exactly one result
// beat per input beat, in order; tuser is the status, tdata the inserted
// token length, the line length after the item and the character read.
// Each item passes through the sequencer states: a clear, a flagged item and
// a plain backspace go straight to the result; a read fetches one character
// from the store; an insert moves the tail, if there is one, and then writes
// the token one character at a time; a backspace with a tail moves the tail.
// The tail move streams one character a cycle through the single-read,
// single-write line store; items are taken one at a time, the next one in the
// cycle after the result leaves the sequencer.
// Reset empties the line at once (length zero, no result pending); no sweep
// of the store is needed because characters beyond the length are never read.
// When the receiver stalls, one finished result waits in the output register
// while the next item is already taken and worked on; that item then holds
// until the register frees.
module calculator_key_line_editor_unit #(
    parameter int LINE_LEN = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // key_code[7:0], cursor[13:8], zero[15:14]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // token_length[2:0], new_length[8:3],
                                        // read_char[16:9], zero[23:17]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import ckle_pkg::*;

    localparam int ADDR_W = $clog2(LINE_LEN);

    logic              res_valid, res_ready;
    t_result           res;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [CHAR_W-1:0] rd_data, wr_data;
    logic              r_out_valid;
    t_result           r_out;

    ckle_ctrl #(
        .LINE_LEN (LINE_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (t_kind'(s_axis_tuser)),
        .i_key_code  (s_axis_tdata[7:0]),
        .i_cursor    (s_axis_tdata[13:8]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    ckle_store #(
        .DEPTH (LINE_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {7'd0, r_out.rch, r_out.new_len, r_out.tlen};

endmodule

// ===== hdl/ckle_store.sv =====
// Line character store: one write port, one read port with registered data.
module ckle_store #(
    parameter int DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [ckle_pkg::CHAR_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [ckle_pkg::CHAR_W-1:0] i_wr_data
);
    import ckle_pkg::*;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ckle_ctrl.sv =====
// Item sequencer: checks, tail shift, token write and read through the store.
`include "calculator_key_line_editor_unit_macros.svh"

module ckle_ctrl #(
    parameter int LINE_LEN = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ckle_pkg::t_kind               i_kind,
    input  logic [ckle_pkg::KEY_W-1:0]    i_key_code,
    input  logic [ckle_pkg::CURSOR_W-1:0] i_cursor,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ckle_pkg::t_result             o_res,
    output logic                          o_rd_en,
    output logic [$clog2(LINE_LEN)-1:0]   o_rd_addr,
    input  logic [ckle_pkg::CHAR_W-1:0]   i_rd_data,
    output logic                          o_wr_en,
    output logic [$clog2(LINE_LEN)-1:0]   o_wr_addr,
    output logic [ckle_pkg::CHAR_W-1:0]   o_wr_data
);
    import ckle_pkg::*;

    localparam int ADDR_W = $clog2(LINE_LEN);
    localparam int LEN_W  = $clog2(LINE_LEN + 1);
    localparam int CMP_W  = ((LEN_W > CURSOR_W) ? LEN_W : CURSOR_W) + 1;

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [CURSOR_W-1:0] r_cur, n_cur;
    t_token              r_tok, n_tok;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic                r_more, n_more;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_pend_addr, n_pend_addr;
    logic [TLEN_W-1:0]   r_tidx, n_tidx;
    t_status             r_status, n_status;
    logic [TLEN_W-1:0]   r_tlen, n_tlen;
    logic [CHAR_W-1:0]   r_rch, n_rch;

    logic [CMP_W-1:0] cur_w, len_w, tlen_w, sum_w, limit_w;
    logic             cur_over, cur_at_end, has_tail, cur_zero, bad_key, no_room;
    logic             last_rd, last_tok, shift_end;
    logic [ADDR_W-1:0] shift_dst, tok_addr;

    assign cur_w      = CMP_W'(r_cur);
    assign len_w      = CMP_W'(r_len);
    assign tlen_w     = CMP_W'(r_tok.len);
    assign sum_w      = len_w + tlen_w;
    assign limit_w    = CMP_W'(LINE_LEN);
    assign bad_key    = (r_tok.len == '0);
    assign cur_over   = (cur_w > len_w);
    assign cur_at_end = (cur_w >= len_w);
    assign has_tail   = (len_w > cur_w);
    assign cur_zero   = (r_cur == '0);
    assign no_room    = (sum_w > limit_w);
    assign last_rd    = (r_kind == K_INSERT) ? (CMP_W'(r_idx) == cur_w)
                                             : (CMP_W'(r_idx) == len_w - CMP_W'(1));
    assign last_tok   = (r_tidx == r_tok.len - TLEN_W'(1));
    assign shift_end  = r_pend && !r_more;
    assign shift_dst  = (r_kind == K_INSERT) ? ADDR_W'(CMP_W'(r_pend_addr) + tlen_w)
                                             : (r_pend_addr - ADDR_W'(1));
    assign tok_addr   = ADDR_W'(cur_w + CMP_W'(r_tidx));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    K_INSERT: begin
                        priority if (bad_key || cur_over || no_room) begin
                            n_state = S_DONE;
                        end else if (has_tail) begin
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_TOKEN;
                        end
                    end
                    K_BACKSPACE: begin
                        priority if (cur_over || cur_zero || !has_tail) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end
                    K_CLEAR: n_state = S_DONE;
                    K_READ:  n_state = cur_at_end ? S_DONE : S_READ;
                    default: n_state = S_DONE;
                endcase
            end
            S_SHIFT: begin
                if (shift_end) begin
                    n_state = (r_kind == K_INSERT) ? S_TOKEN : S_DONE;
                end
            end
            S_TOKEN: begin
                if (last_tok) begin
                    n_state = S_DONE;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_kind      = r_kind;
        n_cur       = r_cur;
        n_tok       = r_tok;
        n_len       = r_len;
        n_idx       = r_idx;
        n_more      = r_more;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_tidx      = r_tidx;
        n_status    = r_status;
        n_tlen      = r_tlen;
        n_rch       = r_rch;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;
        o_wr_en     = 1'b0;
        o_wr_addr   = shift_dst;
        o_wr_data   = i_rd_data;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_kind     = i_kind;
                n_cur      = i_cursor;
                n_tok      = key_token(i_key_code);
            end
            S_EXEC: begin
                n_status = ST_DONE;
                n_tlen   = '0;
                n_rch    = '0;
                n_tidx   = '0;
                n_more   = 1'b1;
                unique case (r_kind)
                    K_INSERT: begin
                        priority if (bad_key) begin
                            n_status = ST_UNKNOWN;
                        end else if (cur_over) begin
                            n_status = ST_BAD_CURSOR;
                        end else if (no_room) begin
                            n_status = ST_NO_ROOM;
                        end else begin
                            n_idx = ADDR_W'(len_w - CMP_W'(1));
                        end
                    end
                    K_BACKSPACE: begin
                        priority if (cur_over) begin
                            n_status = ST_BAD_CURSOR;
                        end else if (cur_zero) begin
                            n_status = ST_DONE;
                        end else if (has_tail) begin
                            n_idx = ADDR_W'(cur_w);
                        end else begin
                            n_len = r_len - LEN_W'(1);
                        end
                    end
                    K_CLEAR: n_len = '0;
                    K_READ: begin
                        if (cur_at_end) begin
                            n_status = ST_BAD_CURSOR;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = ADDR_W'(cur_w);
                        end
                    end
                    default: n_status = ST_DONE;
                endcase
            end
            S_SHIFT: begin
                o_rd_en = r_more;
                o_wr_en = r_pend;
                if (r_more) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx;
                    if (last_rd) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = (r_kind == K_INSERT) ? (r_idx - ADDR_W'(1))
                                                     : (r_idx + ADDR_W'(1));
                    end
                end
                if (shift_end && r_kind == K_BACKSPACE) begin
                    n_len = r_len - LEN_W'(1);
                end
            end
            S_TOKEN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = tok_addr;
                o_wr_data = r_tok.chars[r_tidx];
                n_tidx    = r_tidx + TLEN_W'(1);
                if (last_tok) begin
                    n_len  = r_len + LEN_W'(r_tok.len);
                    n_tlen = r_tok.len;
                end
            end
            S_READ: n_rch = i_rd_data;
            S_DONE: o_res_valid = 1'b1;
            default: n_status = r_status;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_more  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_more  <= n_more;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_cur       <= n_cur;
        r_tok       <= n_tok;
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_tidx      <= n_tidx;
        r_status    <= n_status;
        r_tlen      <= n_tlen;
        r_rch       <= n_rch;
    end

    assign o_res = '{status: r_status, tlen: r_tlen, new_len: OLEN_W'(r_len), rch: r_rch};

    `CKLE_ASSERT(a_len_bound, i_clk, i_rst_n, (CMP_W'(r_len) <= limit_w), "length over capacity")
    `CKLE_ASSERT(a_wr_range, i_clk, i_rst_n, o_wr_en |-> (CMP_W'(o_wr_addr) < limit_w), "write out of range")
    `CKLE_ASSERT(a_rw_apart, i_clk, i_rst_n, (o_rd_en && o_wr_en) |-> (o_rd_addr != o_wr_addr), "read and write collide")
    `CKLE_ASSERT(a_accept_exec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_EXEC), "accepted beat not executed")
    `CKLE_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, (r_len == '0 && r_state == S_IDLE), "reset left line state")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the calculator key line editor unit.
`timescale 1ns / 100ps

module tb_top;
    import ckle_pkg::*;

    localparam int LINE_LEN    = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_KEYS = 1330;
    localparam int DRAIN_WAIT  = 60;

    typedef struct packed {
        t_kind             kind;
        logic [KEY_W-1:0]  code;
        logic [CURSOR_W-1:0] cur;
    } t_key_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // key_code[7:0], cursor[13:8], zero[15:14]
    logic [1:0]  s_axis_tuser = K_INSERT;  // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // token_length[2:0], new_length[8:3],
                                       // read_char[16:9], zero[23:17]
    logic [1:0]  m_axis_tuser;         // status[1:0]

    t_key_item key_beats[$];
    t_result   line_results[$];
    logic [7:0] valid_codes[$];

    logic [CHAR_W-1:0] line_img [LINE_LEN];
    int line_len = 0;
    int gen_len  = 0;

    int n_errors = 0;
    int n_checked = 0;
    int n_sent = 0;
    int n_ins_ok = 0;
    int n_ins_flag = 0;
    int n_bksp = 0;
    int n_read = 0;
    int n_clear = 0;
    int peak_len = 0;
    int cycle_cnt = 0;

    t_key_item drv_item = '0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_mode = 0;

    calculator_key_line_editor_unit #(
        .LINE_LEN(LINE_LEN)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic string token_text(input logic [KEY_W-1:0] code);
        string s;
        s = "";
        if (code >= 8'h2A && code <= 8'h39) begin
            s = " ";
            s[0] = code;
        end else begin
            case (code)
                8'h83:  s = "e";
                8'h06:  s = "(";
                8'h07:  s = ")";
                8'h8B:  s = "i";
                8'h8E:  s = "!";
                8'hB1:  s = "x";
                8'hB2:  s = "y";
                8'hB3:  s = "z";
                8'h0D:  s = "^";
                8'd18:  s = "sin(";
                8'd19:  s = "cos(";
                8'd20:  s = "tan(";
                8'd12:  s = "^2";
                8'd15:  s = "e^(";
                8'h8F:  s = "ln(";
                8'd23:  s = "Ans";
                8'd11:  s = "abs(";
                8'd16:  s = "10^(";
                8'h90:  s = "log(";
                8'h92:  s = "asin(";
                8'h93:  s = "acos(";
                8'h94:  s = "atan(";
                8'h8C:  s = "^(1/2)";
                8'h8D:  s = "^(1/";
                8'd14:  s = "^(-1)";
                8'd120: s = "sinh(";
                8'd121: s = "cosh(";
                8'd122: s = "tanh(";
                default: s = "";
            endcase
        end
        return s;
    endfunction

    function automatic void apply_key_beat(input t_key_item it);
        string   tok;
        t_result r;
        int      n;
        int      cur;
        tok = token_text(it.code);
        n = tok.len();
        cur = int'(it.cur);
        r.status = ST_DONE;
        r.tlen = '0;
        r.rch = '0;
        case (it.kind)
            K_INSERT: begin
                if (n == 0) begin
                    r.status = ST_UNKNOWN;
                end else if (cur > line_len) begin
                    r.status = ST_BAD_CURSOR;
                end else if (line_len + n > LINE_LEN) begin
                    r.status = ST_NO_ROOM;
                end else begin
                    for (int i = line_len; i > cur; i--)
                        line_img[i - 1 + n] = line_img[i - 1];
                    for (int i = 0; i < n; i++)
                        line_img[cur + i] = tok[i];
                    line_len += n;
                    r.tlen = n[TLEN_W-1:0];
                end
                if (r.status == ST_DONE) n_ins_ok++;
                else n_ins_flag++;
            end
            K_BACKSPACE: begin
                n_bksp++;
                if (cur > line_len) begin
                    r.status = ST_BAD_CURSOR;
                end else if (cur > 0) begin
                    for (int i = cur; i < line_len; i++)
                        line_img[i - 1] = line_img[i];
                    line_img[line_len - 1] = '0;
                    line_len--;
                end
            end
            K_CLEAR: begin
                n_clear++;
                for (int i = 0; i < LINE_LEN; i++)
                    line_img[i] = '0;
                line_len = 0;
            end
            default: begin
                n_read++;
                if (cur >= line_len) r.status = ST_BAD_CURSOR;
                else r.rch = line_img[cur];
            end
        endcase
        if (line_len > peak_len) peak_len = line_len;
        r.new_len = line_len[OLEN_W-1:0];
        line_results.push_back(r);
    endfunction

    task automatic push_beat(input t_kind kind, input int code, input int cur);
        t_key_item it;
        int        n;
        string     tok;
        it.kind = kind;
        it.code = code[KEY_W-1:0];
        it.cur = cur[CURSOR_W-1:0];
        key_beats.push_back(it);
        tok = token_text(it.code);
        n = tok.len();
        case (kind)
            K_INSERT:
                if (n > 0 && it.cur <= gen_len && gen_len + n <= LINE_LEN) gen_len += n;
            K_BACKSPACE:
                if (it.cur <= gen_len && it.cur > 0) gen_len--;
            K_CLEAR:
                gen_len = 0;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 30)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     n_checked, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        logic busy;
        busy = s_axis_tvalid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_key_beat(drv_item);
                n_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (key_beats.size() > 0) begin
                    drv_item = key_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, drv_item.cur, drv_item.code};
                    s_axis_tuser <= drv_item.kind;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt % 128 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (cycle_cnt % 4 == 0);
            default: m_axis_tready <= (cycle_cnt % 37 < 5);
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (line_results.size() == 0) begin
                report_mismatch("unexpected beat, status", int'(m_axis_tuser), 0);
            end else begin
                want = line_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch("status", int'(m_axis_tuser), int'(want.status));
                if (m_axis_tdata[2:0] != want.tlen)
                    report_mismatch("token_length", int'(m_axis_tdata[2:0]),
                                    int'(want.tlen));
                if (m_axis_tdata[8:3] != want.new_len)
                    report_mismatch("new_length", int'(m_axis_tdata[8:3]),
                                    int'(want.new_len));
                if (m_axis_tdata[16:9] != want.rch)
                    report_mismatch("read_char", int'(m_axis_tdata[16:9]),
                                    int'(want.rch));
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", line_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int r;
        int cur;
        int ins_w;
        string tt;
        for (int i = 0; i < LINE_LEN; i++)
            line_img[i] = '0;
        for (int c = 0; c < 256; c++) begin
            tt = token_text(c[7:0]);
            if (tt.len() > 0) valid_codes.push_back(c[7:0]);
        end

        push_beat(K_READ, 'h00, 0);
        push_beat(K_BACKSPACE, 'h00, 0);
        push_beat(K_INSERT, 'h00, 0);
        push_beat(K_INSERT, 'hFF, 63);
        push_beat(K_INSERT, 'h8C, 0);
        push_beat(K_INSERT, 'h2A, 0);
        push_beat(K_INSERT, 'h39, 7);
        push_beat(K_INSERT, 18, 3);
        push_beat(K_INSERT, 'h2B, 40);
        push_beat(K_READ, 'hFF, 11);
        push_beat(K_READ, 'h00, 12);
        push_beat(K_BACKSPACE, 'hFF, 63);
        push_beat(K_BACKSPACE, 'h00, 12);
        push_beat(K_BACKSPACE, 'h00, 1);
        push_beat(K_INSERT, 'h8C, 0);
        push_beat(K_INSERT, 14, 5);
        push_beat(K_INSERT, 120, 20);
        push_beat(K_INSERT, 'h8C, 0);
        push_beat(K_INSERT, 23, 31);
        push_beat(K_INSERT, 'h83, 30);
        push_beat(K_INSERT, 'h2A, 32);
        push_beat(K_INSERT, 'h2A, 33);
        push_beat(K_READ, 'h00, 31);
        push_beat(K_CLEAR, 'hFF, 63);
        push_beat(K_READ, 'h00, 0);

        for (int k = 0; k < RANDOM_KEYS; k++) begin
            r = $urandom_range(0, 99);
            ins_w = (gen_len > 20) ? 30 : 55;
            if (r < ins_w) begin
                cur = $urandom_range(0, gen_len);
                push_beat(K_INSERT,
                          int'(valid_codes[$urandom_range(0, valid_codes.size() - 1)]),
                          cur);
            end else if (r < ins_w + 25) begin
                push_beat(K_BACKSPACE, $urandom_range(0, 255), $urandom_range(0, gen_len));
            end else if (r < ins_w + 40) begin
                cur = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
                push_beat(K_READ, $urandom_range(0, 255), cur);
            end else if (r < ins_w + 42) begin
                push_beat(K_CLEAR, $urandom_range(0, 255), $urandom_range(0, 63));
            end else begin
                push_beat(t_kind'($urandom_range(0, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 63));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (key_beats.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (line_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (line_results.size() != 0)
            report_mismatch("results left over", line_results.size(), 0);
        $display("sent %0d key beats: %0d inserts taken, %0d flagged, %0d backspaces,",
                 n_sent, n_ins_ok, n_ins_flag, n_bksp);
        $display("%0d reads, %0d clears; %0d results checked, longest line %0d chars",
                 n_read, n_clear, n_checked, peak_len);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== calculator_key_line_editor_unit.f =====
+incdir+hdl
hdl/ckle_pkg.sv
hdl/ckle_store.sv
hdl/ckle_ctrl.sv
hdl/calculator_key_line_editor_unit.sv
tb/sv/tb_top.sv
